[src/css_pkg.sv]
// ----------------------------------------------------------------------------
// Caseless substring search package
// Shared constants, register indexes and the lower-case fold helper.
// ----------------------------------------------------------------------------
package css_pkg;

   // Default window depth and text position range
   localparam int unsigned MAX_PATTERN_DEFAULT = 16;
   localparam longint unsigned MAX_TEXT_DEFAULT = 64'd65536;

   // Bytes held by the two pattern registers together
   localparam int unsigned PATTERN_BYTES = 16;

   // Widths of the fixed fields
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned LEN_W = 5;
   localparam int unsigned START_W = 16;
   localparam int unsigned CSR_DATA_W = 64;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned RSP_DATA_W = 24;

   // Register indexes of the control port
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LOW = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_HIGH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH = 2'd2;

   // Fold A-Z to lower case, leave every other byte as is
   function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] c);
      logic [BYTE_W-1:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage

[src/caseless_substring_search.sv]
// ----------------------------------------------------------------------------
// Caseless substring search
// Slides a lower-cased window over a text stream, compares it with the
// configured pattern and reports the first match position on the last byte.
// ----------------------------------------------------------------------------
// A text's result is registered as its last byte is accepted. Throughput: one
// text byte per cycle while the skid is empty; the window compare is a single
// layer of byte comparators feeding the result register. A two-entry result
// stage (output register plus skid) keeps req ready while one result waits.
// Reset (synchronous, active high) clears the window, counters, flags, the
// result stage and all pattern registers.
module caseless_substring_search #(
   parameter int unsigned MAX_PATTERN = css_pkg::MAX_PATTERN_DEFAULT,
   parameter longint unsigned MAX_TEXT = css_pkg::MAX_TEXT_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Text request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [css_pkg::BYTE_W-1:0]           req_tdata,  // [7:0] text_byte
   input  logic                                 req_tlast,  // text_last
   // Result channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [0] match_found, [16:1] match_start, [17] length_overflow, [23:18] zero
   output logic [css_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // Control register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [css_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [css_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int unsigned CNT_W = $clog2(MAX_TEXT + 64'd1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TEXT);

   typedef logic [css_pkg::BYTE_W-1:0] byte_type;

   typedef struct packed {
      logic                          found;
      logic [css_pkg::START_W-1:0]   start;
      logic                          overflow;
   } result_type;

   // Configuration
   logic [css_pkg::CSR_DATA_W-1:0] pat_low_ff;
   logic [css_pkg::CSR_DATA_W-1:0] pat_high_ff;
   logic [css_pkg::LEN_W-1:0]      pat_len_ff;

   // Search state
   byte_type                       win_ff [MAX_PATTERN];
   byte_type                       win_in [MAX_PATTERN];
   logic [CNT_W-1:0]               seen_ff;
   logic [CNT_W-1:0]               seen_in;
   logic                           found_ff;
   logic                           found_in;
   logic [css_pkg::START_W-1:0]    first_ff;
   logic [css_pkg::START_W-1:0]    first_in;
   logic                           ovf_ff;
   logic                           ovf_in;

   // Result stage
   logic                           rsp_valid_ff;
   result_type                     rsp_data_ff;
   logic                           skid_valid_ff;
   result_type                     skid_data_ff;

   // Datapath
   byte_type                       pat_fold [css_pkg::PATTERN_BYTES];
   byte_type                       aligned [MAX_PATTERN];
   logic [MAX_PATTERN-1:0]         lane_ok;
   logic                           req_acc;
   logic                           push;
   logic                           pop;
   logic                           saturated;
   logic [CNT_W-1:0]               seen_next;
   logic                           len_ok;
   logic                           match_now;
   logic [css_pkg::START_W-1:0]    start_now;
   result_type                     result_in;

   assign csr_ready = 1'b1;
   assign req_tready = !skid_valid_ff;
   assign req_acc = req_tvalid && req_tready;
   assign push = req_acc && req_tlast;
   assign pop = rsp_valid_ff && rsp_tready;

   // Fold the pattern bytes
   always_comb begin
      for (int k = 0; k < int'(css_pkg::PATTERN_BYTES); k++) begin
         if (k < 8) begin
            pat_fold[k] = css_pkg::fold(pat_low_ff[8*k +: 8]);
         end else begin
            pat_fold[k] = css_pkg::fold(pat_high_ff[8*(k-8) +: 8]);
         end
      end
   end

   // Line pattern bytes up with window slots: slot j holds pattern byte len-1-j
   always_comb begin
      logic [6:0] pidx;
      for (int j = 0; j < int'(MAX_PATTERN); j++) begin
         pidx = 7'(int'(pat_len_ff) - 1 - j);
         aligned[j] = '0;
         if (j < int'(pat_len_ff) && pidx < 7'(css_pkg::PATTERN_BYTES)) begin
            aligned[j] = pat_fold[pidx[3:0]];
         end
      end
   end

   // Shift the folded byte into the window
   always_comb begin
      win_in[0] = css_pkg::fold(req_tdata);
      for (int i = 1; i < int'(MAX_PATTERN); i++) begin
         win_in[i] = win_ff[i-1];
      end
   end

   // Compare every slot in use
   always_comb begin
      for (int j = 0; j < int'(MAX_PATTERN); j++) begin
         lane_ok[j] = (j >= int'(pat_len_ff)) || (win_in[j] == aligned[j]);
      end
   end

   assign saturated = (seen_ff == CNT_MAX);
   assign seen_next = seen_ff + CNT_W'(1);
   assign len_ok = (pat_len_ff != '0) && (int'(pat_len_ff) <= int'(MAX_PATTERN));
   assign match_now = !saturated && !found_ff && len_ok &&
                      (seen_next >= CNT_W'(pat_len_ff)) && (&lane_ok);
   assign start_now = css_pkg::START_W'(seen_next - CNT_W'(pat_len_ff));

   // Next search state
   always_comb begin
      seen_in = saturated ? seen_ff : seen_next;
      found_in = found_ff || match_now;
      first_in = found_ff ? first_ff : start_now;
      ovf_in = ovf_ff || saturated;
      result_in.found = found_in;
      result_in.start = found_in ? first_in : '0;
      result_in.overflow = ovf_in;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff <= '0;
         pat_high_ff <= '0;
         pat_len_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            css_pkg::CSR_PATTERN_LOW: begin
               pat_low_ff <= csr_data;
            end
            css_pkg::CSR_PATTERN_HIGH: begin
               pat_high_ff <= csr_data;
            end
            css_pkg::CSR_PATTERN_LENGTH: begin
               pat_len_ff <= csr_data[css_pkg::LEN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Advance the search on each accepted request, clear after the last one
   always_ff @(posedge clock) begin
      if (reset || push) begin
         for (int i = 0; i < int'(MAX_PATTERN); i++) begin
            win_ff[i] <= '0;
         end
         seen_ff <= '0;
         found_ff <= 1'b0;
         first_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (req_acc) begin
         win_ff <= win_in;
         seen_ff <= seen_in;
         found_ff <= found_in;
         first_ff <= first_in;
         ovf_ff <= ovf_in;
      end
   end

   // Output register with skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            rsp_data_ff <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!rsp_valid_ff || pop) begin
            rsp_data_ff <= result_in;
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_data_ff <= result_in;
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {6'd0, rsp_data_ff.overflow, rsp_data_ff.start, rsp_data_ff.found};

   // A waiting skid entry always sits behind a held output
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held without output entry");

   // State is clear after the last byte of a text
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      push |=> (seen_ff == '0) && !found_ff && !ovf_ff)
      else $error("search state not cleared after last byte");

   // Overflow only once the position counter has saturated
   a_ovf_saturated: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (seen_ff == CNT_MAX))
      else $error("overflow flag without saturated counter");

   // A result blocked by a stalled output lands in the skid entry
   a_push_to_skid: assert property (@(posedge clock) disable iff (reset)
      (push && rsp_valid_ff && !rsp_tready) |=> skid_valid_ff)
      else $error("result lost while output stalled");

endmodule
